### src/mrr_pkg.sv
`default_nettype none

package mrr_pkg;

    // Field widths fixed by the Modbus frame and the register map.
    localparam int ADDR_W       = 8;
    localparam int WORD_W       = 16;
    localparam int PCT_W        = 10;
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;
    localparam int REPLY_LENGTH = 7;
    localparam int COUNT_W      = $clog2(REPLY_LENGTH + 1);
    localparam int REPLY_IDX_W  = $clog2(REPLY_LENGTH);

    // The reply carries address, function, byte count and two data bytes
    // ahead of its CRC.
    localparam int REPLY_CRC_BYTES = REPLY_LENGTH - 2;

    // Scaling: the quotient of the span division never reaches 1024.
    localparam int QUOT_W     = PCT_W;
    localparam int DIVIDEND_W = WORD_W + PCT_W;

    localparam logic [WORD_W-1:0] CRC_INIT          = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY          = 16'hA001;
    localparam logic [ADDR_W-1:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [WORD_W-1:0] QUANTITY_ONE      = 16'h0001;

    localparam logic [WORD_W-1:0] PERCENT_MAX   = 16'd100;
    localparam logic [PCT_W-1:0]  TENTHS_PER_PC = 10'd10;
    localparam logic [PCT_W-1:0]  PCT_FULL      = 10'd1000;

    // Register reset values.
    localparam logic [ADDR_W-1:0] RST_DEVICE_ADDRESS   = 8'd1;
    localparam logic [WORD_W-1:0] RST_REGISTER_ADDRESS = 16'd0;
    localparam logic [WORD_W-1:0] RST_TIMEOUT_TICKS    = 16'd1000;
    localparam logic [WORD_W-1:0] RST_RAW_OFFSET       = 16'd0;
    localparam logic [WORD_W-1:0] RST_RAW_FULL_SCALE   = 16'd4095;
    localparam logic [PCT_W-1:0]  RST_WET_THRESHOLD    = 10'd500;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_RX_BYTE = 2'd1,
        MODE_TICK    = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_CRC     = 2'd2,
        ST_ADDR    = 2'd3
    } status_t;

    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_READING = 1'b1;

    typedef enum logic [2:0] {
        REG_DEVICE_ADDRESS   = 3'd0,
        REG_REGISTER_ADDRESS = 3'd1,
        REG_TIMEOUT_TICKS    = 3'd2,
        REG_RAW_OFFSET       = 3'd3,
        REG_RAW_FULL_SCALE   = 3'd4,
        REG_VALUE_IS_PERCENT = 3'd5,
        REG_WET_THRESHOLD    = 3'd6,
        REG_UNUSED           = 3'd7
    } reg_idx_t;

    // Command to the bit-serial CRC unit.
    typedef struct packed {
        logic              load;
        logic              init;
        logic [ADDR_W-1:0] data;
    } crc_ctrl_t;

endpackage

`default_nettype wire

### src/mrr_crc.sv
`default_nettype none

// Bit-serial CRC-16 (reflected polynomial), one shift per cycle.
module mrr_crc
    import mrr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire crc_ctrl_t         ctrl,
    output logic                   busy,
    output logic [WORD_W-1:0]      crc
);

    logic [WORD_W-1:0] crc_reg, crc_next;
    logic [2:0]        bit_reg, bit_next;
    logic              busy_reg, busy_next;

    always_comb
    begin
        crc_next  = crc_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (ctrl.load)
        begin
            crc_next  = (ctrl.init ? CRC_INIT : crc_reg) ^ {{(WORD_W-ADDR_W){1'b0}}, ctrl.data};
            bit_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
            bit_next = bit_reg + 3'd1;
            if (bit_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            bit_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            crc_reg  <= crc_next;
            bit_reg  <= bit_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign crc  = crc_reg;

endmodule

`default_nettype wire

### src/mrr_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUOT_W bits, so the upper dividend half is below the
// divisor at the start.
module mrr_div
    import mrr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [WORD_W-1:0]     divisor,
    output logic                       busy,
    output logic [QUOT_W-1:0]          quotient
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;

    logic [WORD_W:0]   shifted;
    logic [WORD_W+1:0] trial;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[QUOT_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, div_reg};
    assign fits    = ~trial[WORD_W+1];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = dividend[DIVIDEND_W-1:QUOT_W];
            quo_next  = dividend[QUOT_W-1:0];
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
            quo_next = {quo_reg[QUOT_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### src/modbus_rtu_register_reader.sv
// Modbus RTU master that reads one holding register and turns it into a
// wetness figure in tenths of a percent.
// Input channel (in_valid/in_ready, fields mode and rx_byte): a start
// transaction makes the block send an eight-byte read request, a received
// byte transaction feeds the reply, and a tick transaction advances the
// reply timeout. Output channel (out_valid/out_ready): request bytes with
// kind 0, the eighth flagged last, or one reading outcome with kind 1.
// A start runs the first six request bytes through the shared bit-serial
// CRC unit; all eight request bytes then follow one per accepted output
// transaction. Each of the first five reply bytes holds the input while
// the CRC unit folds it in; the sixth is only stored. The seventh byte
// starts a check and, for a scaled value, a multiply and a ten-step
// divide whose quotient becomes the percentage of the outcome.
// Reset sets the configuration registers to their documented defaults and leaves the
// block idle, not waiting for a reply. When the receiver stalls, the output
// register holds its transaction; the block still accepts the next input
// transaction, but stops before producing another result until the held
// one has gone. Configuration goes through the APB port with pready tied
// high, and is to be written only while the block is idle.
`default_nettype none

module modbus_rtu_register_reader
    import mrr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         mode,
    input  wire logic [ADDR_W-1:0]  rx_byte,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    kind,
    output logic [ADDR_W-1:0]       tx_byte,
    output logic                    last,
    output logic [1:0]              status,
    output logic [WORD_W-1:0]       raw_value,
    output logic [PCT_W-1:0]        percent_tenths,
    output logic                    is_wet
);

    // Sequencer states.
    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_REQ_CRC  = 9'b000000010,
        S_REQ_SEND = 9'b000000100,
        S_RX_CRC   = 9'b000001000,
        S_CHECK    = 9'b000010000,
        S_MUL      = 9'b000100000,
        S_DIV_LOAD = 9'b001000000,
        S_DIV_WAIT = 9'b010000000,
        S_RESULT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [ADDR_W-1:0] device_address_reg;
    logic [WORD_W-1:0] register_address_reg;
    logic [WORD_W-1:0] timeout_ticks_reg;
    logic [WORD_W-1:0] raw_offset_reg;
    logic [WORD_W-1:0] raw_full_scale_reg;
    logic              value_is_percent_reg;
    logic [PCT_W-1:0]  wet_threshold_reg;

    // Transaction state.
    logic               awaiting_reg, awaiting_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0]  ticks_reg, ticks_next;
    logic [2:0]         idx_reg, idx_next;
    logic [ADDR_W-1:0]  reply_mem [REPLY_LENGTH];
    logic               reply_we;

    // Outcome held between the check and the output register.
    logic [1:0]            res_status_reg, res_status_next;
    logic [WORD_W-1:0]     res_raw_reg, res_raw_next;
    logic [PCT_W-1:0]      res_pct_reg, res_pct_next;
    logic [DIVIDEND_W-1:0] prod_reg, prod_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic              out_load;
    logic              out_kind_reg, out_kind_next;
    logic [ADDR_W-1:0] out_tx_reg, out_tx_next;
    logic              out_last_reg, out_last_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [WORD_W-1:0] out_raw_reg, out_raw_next;
    logic [PCT_W-1:0]  out_pct_reg, out_pct_next;
    logic              out_wet_reg, out_wet_next;

    logic in_fire;
    logic out_free;
    logic cfg_write;

    // Shared units.
    crc_ctrl_t         crc_ctrl;
    logic              crc_busy;
    logic [WORD_W-1:0] crc_value;
    logic              div_start;
    logic              div_busy;
    logic [QUOT_W-1:0] div_quotient;

    logic [2:0]        req_sel;
    logic [ADDR_W-1:0] req_byte;
    logic [WORD_W-1:0] reply_raw;
    logic [WORD_W-1:0] reply_crc;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] excess;
    logic [6:0]        pct_clip;

    mrr_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .busy  (crc_busy),
        .crc   (crc_value)
    );

    mrr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (span),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid & in_ready;
    assign out_free = ~out_valid_reg | out_ready;

    // ---------------------------------------------------------------
    // APB register file. Registers sit on word addresses; the write
    // completes in the access phase.
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg   <= RST_DEVICE_ADDRESS;
            register_address_reg <= RST_REGISTER_ADDRESS;
            timeout_ticks_reg    <= RST_TIMEOUT_TICKS;
            raw_offset_reg       <= RST_RAW_OFFSET;
            raw_full_scale_reg   <= RST_RAW_FULL_SCALE;
            value_is_percent_reg <= 1'b0;
            wet_threshold_reg    <= RST_WET_THRESHOLD;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_DEVICE_ADDRESS:   device_address_reg   <= pwdata[ADDR_W-1:0];
                REG_REGISTER_ADDRESS: register_address_reg <= pwdata[WORD_W-1:0];
                REG_TIMEOUT_TICKS:    timeout_ticks_reg    <= pwdata[WORD_W-1:0];
                REG_RAW_OFFSET:       raw_offset_reg       <= pwdata[WORD_W-1:0];
                REG_RAW_FULL_SCALE:   raw_full_scale_reg   <= pwdata[WORD_W-1:0];
                REG_VALUE_IS_PERCENT: value_is_percent_reg <= pwdata[0];
                REG_WET_THRESHOLD:    wet_threshold_reg    <= pwdata[PCT_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_DEVICE_ADDRESS:   prdata = PDATA_W'(device_address_reg);
            REG_REGISTER_ADDRESS: prdata = PDATA_W'(register_address_reg);
            REG_TIMEOUT_TICKS:    prdata = PDATA_W'(timeout_ticks_reg);
            REG_RAW_OFFSET:       prdata = PDATA_W'(raw_offset_reg);
            REG_RAW_FULL_SCALE:   prdata = PDATA_W'(raw_full_scale_reg);
            REG_VALUE_IS_PERCENT: prdata = PDATA_W'(value_is_percent_reg);
            REG_WET_THRESHOLD:    prdata = PDATA_W'(wet_threshold_reg);
            default:              prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Request frame. While the CRC is being built the mux looks one
    // byte ahead, so that the next byte is ready when the unit frees up.
    // ---------------------------------------------------------------
    assign req_sel = (state_reg == S_REQ_CRC) ? idx_reg + 3'd1 : idx_reg;

    always_comb
    begin
        unique case (req_sel)
            3'd0:    req_byte = device_address_reg;
            3'd1:    req_byte = FUNC_READ_HOLDING;
            3'd2:    req_byte = register_address_reg[15:8];
            3'd3:    req_byte = register_address_reg[7:0];
            3'd4:    req_byte = QUANTITY_ONE[15:8];
            3'd5:    req_byte = QUANTITY_ONE[7:0];
            3'd6:    req_byte = crc_value[7:0];
            default: req_byte = crc_value[15:8];
        endcase
    end

    // Fields of a complete reply; the CRC travels low byte first.
    assign reply_raw = {reply_mem[3], reply_mem[4]};
    assign reply_crc = {reply_mem[6], reply_mem[5]};
    assign span      = raw_full_scale_reg - raw_offset_reg;
    assign excess    = res_raw_reg - raw_offset_reg;
    assign pct_clip  = (reply_raw > PERCENT_MAX) ? PERCENT_MAX[6:0] : reply_raw[6:0];

    // ---------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        awaiting_next   = awaiting_reg;
        count_next      = count_reg;
        ticks_next      = ticks_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_raw_next    = res_raw_reg;
        res_pct_next    = res_pct_reg;
        prod_next       = prod_reg;
        reply_we        = 1'b0;
        crc_ctrl        = '0;
        div_start       = 1'b0;

        out_load        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_tx_next     = out_tx_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_raw_next    = out_raw_reg;
        out_pct_next    = out_pct_reg;
        out_wet_next    = out_wet_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (mode_t'(mode))
                        MODE_START:
                        begin
                            // A start while waiting simply restarts the exchange.
                            awaiting_next = 1'b1;
                            count_next    = '0;
                            ticks_next    = '0;
                            idx_next      = '0;
                            crc_ctrl.load = 1'b1;
                            crc_ctrl.init = 1'b1;
                            crc_ctrl.data = device_address_reg;
                            state_next    = S_REQ_CRC;
                        end
                        MODE_RX_BYTE:
                        begin
                            if (awaiting_reg)
                            begin
                                reply_we   = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                                if (count_reg < COUNT_W'(REPLY_CRC_BYTES))
                                begin
                                    crc_ctrl.load = 1'b1;
                                    crc_ctrl.init = (count_reg == '0);
                                    crc_ctrl.data = rx_byte;
                                    state_next    = S_RX_CRC;
                                end
                                else if (count_reg == COUNT_W'(REPLY_LENGTH - 1))
                                begin
                                    awaiting_next = 1'b0;
                                    count_next    = '0;
                                    state_next    = S_CHECK;
                                end
                            end
                        end
                        MODE_TICK:
                        begin
                            if (awaiting_reg)
                            begin
                                if (ticks_reg >= timeout_ticks_reg)
                                begin
                                    awaiting_next   = 1'b0;
                                    count_next      = '0;
                                    res_status_next = ST_TIMEOUT;
                                    res_raw_next    = '0;
                                    res_pct_next    = '0;
                                    state_next      = S_RESULT;
                                end
                                else
                                begin
                                    ticks_next = ticks_reg + WORD_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_REQ_CRC:
            begin
                if (!crc_busy)
                begin
                    if (idx_reg == 3'd5)
                    begin
                        idx_next   = '0;
                        state_next = S_REQ_SEND;
                    end
                    else
                    begin
                        idx_next      = idx_reg + 3'd1;
                        crc_ctrl.load = 1'b1;
                        crc_ctrl.data = req_byte;
                    end
                end
            end

            S_REQ_SEND:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_kind_next   = KIND_TX;
                    out_tx_next     = req_byte;
                    out_last_next   = (idx_reg == 3'd7);
                    out_status_next = ST_OK;
                    out_raw_next    = '0;
                    out_pct_next    = '0;
                    out_wet_next    = 1'b0;
                    idx_next        = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RX_CRC:
            begin
                if (!crc_busy)
                begin
                    state_next = S_IDLE;
                end
            end

            S_CHECK:
            begin
                res_raw_next = '0;
                res_pct_next = '0;
                state_next   = S_RESULT;
                if (crc_value != reply_crc)
                begin
                    res_status_next = ST_CRC;
                end
                else if (reply_mem[0] != device_address_reg ||
                         reply_mem[1] != FUNC_READ_HOLDING)
                begin
                    res_status_next = ST_ADDR;
                end
                else
                begin
                    res_status_next = ST_OK;
                    res_raw_next    = reply_raw;
                    if (value_is_percent_reg)
                    begin
                        res_pct_next = {3'b000, pct_clip} * TENTHS_PER_PC;
                    end
                    else if (raw_full_scale_reg <= raw_offset_reg)
                    begin
                        res_pct_next = (reply_raw > raw_offset_reg) ? PCT_FULL : '0;
                    end
                    else if (reply_raw <= raw_offset_reg)
                    begin
                        res_pct_next = '0;
                    end
                    else if (reply_raw >= raw_full_scale_reg)
                    begin
                        res_pct_next = PCT_FULL;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end

            S_MUL:
            begin
                prod_next  = DIVIDEND_W'(excess) * DIVIDEND_W'(PCT_FULL);
                state_next = S_DIV_LOAD;
            end

            S_DIV_LOAD:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    res_pct_next = div_quotient;
                    state_next   = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_kind_next   = KIND_READING;
                    out_tx_next     = '0;
                    out_last_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_raw_next    = res_raw_reg;
                    out_pct_next    = res_pct_reg;
                    out_wet_next    = (res_status_reg == ST_OK) &&
                                      (res_pct_reg >= wet_threshold_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            awaiting_reg  <= 1'b0;
            count_reg     <= '0;
            ticks_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            awaiting_reg  <= awaiting_next;
            count_reg     <= count_next;
            ticks_reg     <= ticks_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_raw_reg    <= res_raw_next;
        res_pct_reg    <= res_pct_next;
        prod_reg       <= prod_next;
        out_kind_reg   <= out_kind_next;
        out_tx_reg     <= out_tx_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
        out_raw_reg    <= out_raw_next;
        out_pct_reg    <= out_pct_next;
        out_wet_reg    <= out_wet_next;
    end

    // Reply byte store; every entry is written before the check reads it.
    always_ff @(posedge clk)
    begin
        if (reply_we)
        begin
            reply_mem[count_reg[REPLY_IDX_W-1:0]] <= rx_byte;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_kind_reg;
    assign tx_byte        = out_tx_reg;
    assign last           = out_last_reg;
    assign status         = out_status_reg;
    assign raw_value      = out_raw_reg;
    assign percent_tenths = out_pct_reg;
    assign is_wet         = out_wet_reg;

endmodule

`default_nettype wire

### src/mrr_checker.sv
`default_nettype none

module mrr_checker
    import mrr_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              kind,
    input wire logic [ADDR_W-1:0] tx_byte,
    input wire logic              last,
    input wire logic [1:0]        status,
    input wire logic [WORD_W-1:0] raw_value,
    input wire logic [PCT_W-1:0]  percent_tenths,
    input wire logic              is_wet
);

    // A stalled output transaction keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(tx_byte) &&
            $stable(last) && $stable(status) && $stable(raw_value) &&
            $stable(percent_tenths) && $stable(is_wet))
        else $error("output transaction changed while stalled");

    // A request byte carries nothing of a reading.
    a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_TX |->
            status == ST_OK && raw_value == '0 && percent_tenths == '0 && !is_wet)
        else $error("request byte carries reading fields");

    // A reading is a single, final transaction with the percentage in range.
    a_reading_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_READING |->
            last && tx_byte == '0 && percent_tenths <= PCT_FULL)
        else $error("malformed reading outcome");

    // A failed reading reports no value and is never wet.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_READING && status != ST_OK |->
            raw_value == '0 && percent_tenths == '0 && !is_wet)
        else $error("failed reading carries a value");

    // Wet only on a good reading.
    a_wet_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_wet |-> kind == KIND_READING && status == ST_OK)
        else $error("wet flag without a good reading");

endmodule

bind modbus_rtu_register_reader mrr_checker u_mrr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .tx_byte        (tx_byte),
    .last           (last),
    .status         (status),
    .raw_value      (raw_value),
    .percent_tenths (percent_tenths),
    .is_wet         (is_wet)
);

`default_nettype wire
